[sv/multicycle_cpu_control_fsm_core_defines.svh]
// Assertion macros shared by the checker of multicycle_cpu_control_fsm_core.
// No dependencies; included by the checker file.
`ifndef MULTICYCLE_CPU_CONTROL_FSM_CORE_DEFINES_SVH
`define MULTICYCLE_CPU_CONTROL_FSM_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define MCFSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcfsm check failed");

// Next-cycle implication, off while reset is asserted.
`define MCFSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcfsm check failed");

// Next-cycle implication that also holds across reset.
`define MCFSM_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mcfsm check failed");

`endif

[sv/mcfsm_pkg.sv]
// Types and constants of the multicycle CPU control FSM.
// No dependencies; used by the decoder and the top level.
package mcfsm_pkg;

  typedef enum logic [4:0] {
    ST_FETCH     = 5'd0,
    ST_FETCH2    = 5'd1,
    ST_DECODE    = 5'd2,
    ST_EX_ADD    = 5'd3,
    ST_EX_SUB    = 5'd4,
    ST_EX_AND    = 5'd5,
    ST_EX_OR     = 5'd6,
    ST_EX_NOT    = 5'd7,
    ST_EX_SHL    = 5'd8,
    ST_EX_SHR    = 5'd9,
    ST_EX_LDI    = 5'd10,
    ST_EX_LD     = 5'd11,
    ST_EX_ST     = 5'd12,
    ST_EX_BR     = 5'd13,
    ST_EX_BZ     = 5'd14,
    ST_EX_BN     = 5'd15,
    ST_EX_JAL    = 5'd16,
    ST_EX_JR     = 5'd17,
    ST_QUIT      = 5'd18,
    ST_MEM_LD    = 5'd19,
    ST_MEM_LD2   = 5'd20,
    ST_MEM_ST    = 5'd21,
    ST_WB_ALU    = 5'd22,
    ST_WB_LD     = 5'd23,
    ST_WB_JAL    = 5'd24,
    ST_BR_TAKEN  = 5'd25,
    ST_BR_NOT    = 5'd26
  } state_t;

  localparam logic [3:0] ALU_PC_INC = 4'd10;
  localparam logic [3:0] ALU_BRANCH = 4'd11;
  localparam logic [3:0] ALU_LINK   = 4'd12;
  localparam logic [3:0] ALU_JR     = 4'd13;

  // Datapath control word, addr_select in the lowest bit.
  typedef struct packed {
    logic       mdr_enable;
    logic       mem_write;
    logic       pc_enable;
    logic       regfile_dest_select;
    logic       regfile_write;
    logic       regfile_data_select;
    logic       alu_result_enable;
    logic [3:0] alu_operation;
    logic       b_reg_enable;
    logic       a_reg_enable;
    logic       instr_reg_enable;
    logic       addr_select;
  } ctrl_t;

  // Decoder result for one step.
  typedef struct packed {
    state_t     cur_state;
    state_t     fol_state;
    logic [3:0] opcode;
    ctrl_t      ctrl;
  } dec_t;

endpackage

[sv/multicycle_cpu_control_fsm_core.sv]
// Top level of the multicycle CPU control FSM: state registers and result register.
// Depends on mcfsm_pkg and mcfsm_decode.
//
// Control unit of a multicycle processor. Each accepted input request steps the FSM once:
// the stored next state becomes the current state, its twelve control signals go out as
// one result request, and the following state is picked from the opcode (latched in decode)
// or the ALU flags (branch-if-zero / branch-if-negative). A request with mem_write_active
// set changes nothing and yields no result; one with start_pulse set (and no freeze) returns
// the FSM to fetch, clears the latched opcode and yields no result. Opcode 15 enters a quit
// state that emits all-zero control words until a start request. The decoder sits between
// the state registers and the output register, and in_tready stays high while the output
// register is empty or being drained, so a request can be accepted every clock with its
// result in the next cycle. Reset is synchronous; no clearing pass is needed.
module multicycle_cpu_control_fsm_core
  import mcfsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] mem_write_active, [1] start_pulse, [5:2] instr_opcode, [6] alu_zero,
  // [7] alu_negative
  input  logic [7:0]  in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] addr_select, [1] instr_reg_enable, [2] a_reg_enable, [3] b_reg_enable,
  // [7:4] alu_operation, [8] alu_result_enable, [9] regfile_data_select,
  // [10] regfile_write, [11] regfile_dest_select, [12] pc_enable, [13] mem_write,
  // [14] mdr_enable, [15] zero
  output logic [15:0] out_tdata
);

  state_t     cur_state_r, cur_state_nxt;
  state_t     fol_state_r, fol_state_nxt;
  logic [3:0] opcode_r, opcode_nxt;
  logic       out_valid_r, out_valid_nxt;
  ctrl_t      out_ctrl_r;
  dec_t       dec;

  logic in_fire;
  logic step;     // not frozen
  logic advance;  // not frozen, no restart: produces a result

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign step      = in_fire && !in_tdata[0];
  assign advance   = step && !in_tdata[1];

  mcfsm_decode u_decode (
    .state_in     (fol_state_r),
    .opcode_held  (opcode_r),
    .instr_opcode (in_tdata[5:2]),
    .alu_zero     (in_tdata[6]),
    .alu_negative (in_tdata[7]),
    .dec          (dec)
  );

  always_comb begin
    cur_state_nxt = cur_state_r;
    fol_state_nxt = fol_state_r;
    opcode_nxt    = opcode_r;
    if (step) begin
      if (in_tdata[1]) begin
        // restart
        cur_state_nxt = ST_FETCH;
        fol_state_nxt = ST_FETCH;
        opcode_nxt    = 4'd0;
      end else begin
        cur_state_nxt = dec.cur_state;
        fol_state_nxt = dec.fol_state;
        opcode_nxt    = dec.opcode;
      end
    end
    // result register: load on advance, drop when taken
    if (in_fire) begin
      out_valid_nxt = advance;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r <= ST_FETCH;
      fol_state_r <= ST_FETCH;
      opcode_r    <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_state_r <= cur_state_nxt;
      fol_state_r <= fol_state_nxt;
      opcode_r    <= opcode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ctrl_r <= dec.ctrl;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_ctrl_r};

endmodule

[sv/mcfsm_decode.sv]
// State decoder: control word and state update for one step.
// Depends on mcfsm_pkg.
module mcfsm_decode
  import mcfsm_pkg::*;
(
  input  state_t     state_in,
  input  logic [3:0] opcode_held,
  input  logic [3:0] instr_opcode,
  input  logic       alu_zero,
  input  logic       alu_negative,
  output dec_t       dec
);

  always_comb begin
    dec           = '0;
    dec.cur_state = state_in;
    dec.fol_state = ST_FETCH;
    dec.opcode    = opcode_held;
    case (state_in) inside
      ST_FETCH: begin
        dec.opcode    = 4'd0;
        dec.fol_state = ST_FETCH2;
      end
      ST_FETCH2: begin
        dec.ctrl.instr_reg_enable = 1'b1;
        dec.fol_state             = ST_DECODE;
      end
      ST_DECODE: begin
        dec.opcode            = instr_opcode;
        dec.ctrl.a_reg_enable = 1'b1;
        dec.ctrl.b_reg_enable = 1'b1;
        // opcode 15 lands on the quit code
        dec.fol_state = state_t'(5'(ST_EX_ADD) + {1'b0, instr_opcode});
      end
      [ST_EX_ADD:ST_EX_ST]: begin
        dec.ctrl.alu_operation     = 4'(state_in - ST_EX_ADD);
        dec.ctrl.alu_result_enable = 1'b1;
        if (state_in == ST_EX_LD) begin
          dec.fol_state = ST_MEM_LD;
        end else if (state_in == ST_EX_ST) begin
          dec.fol_state = ST_MEM_ST;
        end else begin
          dec.fol_state = ST_WB_ALU;
        end
      end
      ST_EX_BR, ST_BR_TAKEN: begin
        dec.ctrl.alu_operation = ALU_BRANCH;
        dec.ctrl.pc_enable     = 1'b1;
      end
      ST_EX_BZ: begin
        dec.fol_state = alu_zero ? ST_BR_TAKEN : ST_BR_NOT;
      end
      ST_EX_BN: begin
        dec.fol_state = alu_negative ? ST_BR_TAKEN : ST_BR_NOT;
      end
      ST_EX_JAL: begin
        dec.ctrl.alu_operation     = ALU_PC_INC;
        dec.ctrl.alu_result_enable = 1'b1;
        dec.fol_state              = ST_WB_JAL;
      end
      ST_EX_JR: begin
        dec.ctrl.alu_operation = ALU_JR;
        dec.ctrl.pc_enable     = 1'b1;
      end
      ST_QUIT: begin
        dec.fol_state = ST_QUIT;
      end
      ST_MEM_LD: begin
        dec.ctrl.addr_select = 1'b1;
        dec.fol_state        = ST_MEM_LD2;
      end
      ST_MEM_LD2: begin
        dec.ctrl.mdr_enable = 1'b1;
        dec.fol_state       = ST_WB_LD;
      end
      ST_MEM_ST: begin
        dec.ctrl.mem_write     = 1'b1;
        dec.ctrl.addr_select   = 1'b1;
        dec.ctrl.alu_operation = ALU_PC_INC;
        dec.ctrl.pc_enable     = 1'b1;
      end
      ST_WB_ALU, ST_BR_NOT: begin
        dec.ctrl.regfile_write = (state_in == ST_WB_ALU);
        dec.ctrl.alu_operation = ALU_PC_INC;
        dec.ctrl.pc_enable     = 1'b1;
      end
      ST_WB_LD: begin
        dec.ctrl.regfile_data_select = 1'b1;
        dec.ctrl.regfile_write       = 1'b1;
        dec.ctrl.alu_operation       = ALU_PC_INC;
        dec.ctrl.pc_enable           = 1'b1;
      end
      ST_WB_JAL: begin
        dec.ctrl.regfile_dest_select = 1'b1;
        dec.ctrl.regfile_write       = 1'b1;
        dec.ctrl.alu_operation       = ALU_LINK;
        dec.ctrl.pc_enable           = 1'b1;
      end
      default: begin
        // unused code: all control outputs low, both state registers back to fetch
        dec.cur_state = ST_FETCH;
      end
    endcase
  end

endmodule

[sv/mcfsm_checker.sv]
// Port-level checker for multicycle_cpu_control_fsm_core, with its bind.
// Depends on multicycle_cpu_control_fsm_core_defines.svh.
`include "multicycle_cpu_control_fsm_core_defines.svh"

module mcfsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // no result right after reset
  `MCFSM_ASSERT_NXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_tvalid)
  // a stalled result blocks new requests
  `MCFSM_ASSERT_IMP(a_stall_blocks, clk, rst_n, out_tvalid && !out_tready, !in_tready)
  // freeze or restart requests give no result
  `MCFSM_ASSERT_NXT(a_no_result, clk, rst_n,
    in_tvalid && in_tready && (in_tdata[0] || in_tdata[1]), !out_tvalid)
  // a stepping request gives a result next cycle
  `MCFSM_ASSERT_NXT(a_result, clk, rst_n,
    in_tvalid && in_tready && !in_tdata[0] && !in_tdata[1], out_tvalid)
  // pad bit low, ALU code never 14 or 15
  `MCFSM_ASSERT_IMP(a_word_legal, clk, rst_n, out_tvalid,
    !out_tdata[15] && (out_tdata[7:5] != 3'b111))

endmodule

bind multicycle_cpu_control_fsm_core mcfsm_checker u_mcfsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
